[rtl/core/memory_region_table_assert.svh]
// ----------------------------------------------------------------------------
// memory_region_table_assert.svh
// Assertion macros shared by the region table modules.
// ----------------------------------------------------------------------------
`ifndef MEMORY_REGION_TABLE_ASSERT_SVH
`define MEMORY_REGION_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define MRT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define MRT_ASSERT(label, clk, rst_n, prop, msg)
`define MRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/core/mrt_pkg.sv]
// ----------------------------------------------------------------------------
// mrt_pkg
// Shared types and codes of the memory region table.
// ----------------------------------------------------------------------------
package mrt_pkg;
  localparam int PAGE_SHIFT = 12;
  localparam int ADDR_BITS  = 48;

  localparam logic [2:0] OP_ADD     = 3'd0;
  localparam logic [2:0] OP_FAULT   = 3'd1;
  localparam logic [2:0] OP_REMOVE  = 3'd2;
  localparam logic [2:0] OP_RANGE   = 3'd3;
  localparam logic [2:0] OP_CLEAR   = 3'd4;

  localparam logic [3:0] ST_DONE       = 4'd0;
  localparam logic [3:0] ST_MISALIGNED = 4'd1;
  localparam logic [3:0] ST_EMPTY      = 4'd2;
  localparam logic [3:0] ST_OVERLAP    = 4'd3;
  localparam logic [3:0] ST_FULL       = 4'd4;
  localparam logic [3:0] ST_MAP        = 4'd5;
  localparam logic [3:0] ST_GROWN      = 4'd6;
  localparam logic [3:0] ST_NOREGION   = 4'd7;
  localparam logic [3:0] ST_GUARD      = 4'd8;
  localparam logic [3:0] ST_WDENIED    = 4'd9;
  localparam logic [3:0] ST_STACKLIM   = 4'd10;
  localparam logic [3:0] ST_NOTFOUND   = 4'd11;

  localparam logic [1:0] KIND_STACK = 2'd2;
  localparam logic [1:0] KIND_GUARD = 2'd3;

  localparam logic CFG_STACK_LIMIT = 1'b0;
  localparam logic CFG_WRITE_MASK  = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic latch;     // capture the input item
    logic scan_clr;  // reset scan index and scan flags
    logic scan_step; // issue read of the current slot
    logic eval;      // evaluate the slot read last cycle
    logic commit;    // apply the table update and form the result
  } mrt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;  // current issue index is the last slot
    logic need_scan;  // latched op needs a table scan
  } mrt_stat_t;
endpackage

[rtl/core/mrt_ctrl.sv]
// ----------------------------------------------------------------------------
// mrt_ctrl
// Sequencer: latch, scan every slot through the memory if the op needs it, commit.
// ----------------------------------------------------------------------------
`include "memory_region_table_assert.svh"
module mrt_ctrl
  import mrt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  mrt_stat_t stat,
  output mrt_cmd_t  cmd
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.scan_clr = 1'b1;
        state_nxt = stat.need_scan ? S_SCAN : S_DONE;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        cmd.eval  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.commit = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  `MRT_ASSERT_NEXT(a_start_leaves_idle, clk, rst_n, (start && !busy), busy, "start ignored")
  `MRT_ASSERT_NEXT(a_commit_idle, clk, rst_n, cmd.commit, !busy, "no return to idle")
  `MRT_ASSERT(a_one_cmd, clk, rst_n, $onehot0({cmd.latch, cmd.scan_clr, cmd.commit}), "cmd clash")
endmodule

[rtl/core/mrt_datapath.sv]
// ----------------------------------------------------------------------------
// mrt_datapath
// Slot memory, scan pipeline, table update and result formation.
// ----------------------------------------------------------------------------
`include "memory_region_table_assert.svh"
module mrt_datapath
  import mrt_pkg::*;
#(
  parameter int TABLE_SLOTS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mrt_cmd_t             cmd,
  output mrt_stat_t            stat,
  input  logic                 cfg_valid,
  input  logic                 cfg_index,
  input  logic [47:0]          cfg_data,
  input  logic [2:0]           in_op,
  input  logic [ADDR_BITS-1:0] in_start_addr,
  input  logic [ADDR_BITS-1:0] in_end_addr,
  input  logic [7:0]           in_prot_bits,
  input  logic [1:0]           in_kind_code,
  input  logic                 in_is_write,
  input  logic [5:0]           in_target_entry,
  output logic                 out_valid,
  output logic [3:0]           out_status,
  output logic [5:0]           out_entry_index,
  output logic [47:0]          out_fault_page,
  output logic [7:0]           out_region_prot,
  output logic [1:0]           out_region_kind,
  output logic [6:0]           out_region_count
);
  localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int PW = ADDR_BITS - PAGE_SHIFT;
  localparam int CW = $clog2(TABLE_SLOTS + 1);
  localparam logic [IW-1:0] LAST = IW'(TABLE_SLOTS - 1);

  // configuration
  logic [47:0] stack_limit_r;
  logic [7:0]  wmask_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stack_limit_r <= 48'd8388608;
      wmask_r       <= 8'd2;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_STACK_LIMIT) stack_limit_r <= cfg_data;
      else wmask_r <= cfg_data[7:0];
    end
  end

  // latched item
  logic [2:0]           op_r;
  logic [ADDR_BITS-1:0] s_r, e_r;
  logic [7:0]           prot_in_r;
  logic [1:0]           kind_in_r;
  logic                 wr_r;
  logic [5:0]           tgt_r;
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r <= in_op; s_r <= in_start_addr; e_r <= in_end_addr;
      prot_in_r <= in_prot_bits; kind_in_r <= in_kind_code;
      wr_r <= in_is_write; tgt_r <= in_target_entry;
    end
  end

  logic misal, empty;
  assign misal = (s_r[PAGE_SHIFT-1:0] != '0) || (e_r[PAGE_SHIFT-1:0] != '0);
  assign empty = (s_r >= e_r);
  assign stat.need_scan = ((op_r == OP_ADD) && !misal && !empty) ||
                          (op_r == OP_FAULT) || (op_r == OP_RANGE);

  // valid bits and count
  logic [TABLE_SLOTS-1:0] valid_r;
  logic [CW-1:0]          count_r;

  // slot memory, one read port, one write port
  logic [PW-1:0] mem_lo [TABLE_SLOTS];
  logic [PW-1:0] mem_hi [TABLE_SLOTS];
  logic [7:0]    mem_prot [TABLE_SLOTS];
  logic [1:0]    mem_kind [TABLE_SLOTS];

  logic [IW-1:0] rd_idx_r, ev_idx_r;
  logic          ev_v_r;
  logic [PW-1:0] rd_lo_r, rd_hi_r;
  logic [7:0]    rd_prot_r;
  logic [1:0]    rd_kind_r;

  assign stat.scan_last = (rd_idx_r == LAST);

  logic          we;
  logic [IW-1:0] wa;
  logic [PW-1:0] wlo, whi;
  logic          wfull;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_lo[wa] <= wlo;
      if (wfull) begin
        mem_hi[wa] <= whi; mem_prot[wa] <= prot_in_r; mem_kind[wa] <= kind_in_r;
      end
    end
    if (cmd.scan_step) begin
      rd_lo_r <= mem_lo[rd_idx_r]; rd_hi_r <= mem_hi[rd_idx_r];
      rd_prot_r <= mem_prot[rd_idx_r]; rd_kind_r <= mem_kind[rd_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r <= '0; ev_v_r <= 1'b0;
    end else begin
      ev_v_r <= cmd.scan_step;
      if (cmd.scan_clr) rd_idx_r <= '0;
      else if (cmd.scan_step && !stat.scan_last) rd_idx_r <= rd_idx_r + 1'b1;
      if (cmd.scan_step) ev_idx_r <= rd_idx_r;
    end
  end

  // evaluate one slot per cycle
  logic [ADDR_BITS-1:0] lo_b, hi_b, page;
  logic                 sv, hit_rng, hit_in, nb;
  assign lo_b = {rd_lo_r, {PAGE_SHIFT{1'b0}}};
  assign hi_b = {rd_hi_r, {PAGE_SHIFT{1'b0}}};
  assign page = {s_r[ADDR_BITS-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
  assign sv      = ev_v_r && valid_r[ev_idx_r];
  assign hit_rng = sv && !(hi_b <= s_r || lo_b >= e_r);
  assign hit_in  = sv && (s_r >= lo_b) && (s_r < hi_b);
  // a stack below page one never grows; s in [lo-page, lo) means page == lo-page
  assign nb = sv && (rd_kind_r == KIND_STACK) && (rd_lo_r != '0) &&
              (s_r[ADDR_BITS-1:PAGE_SHIFT] == rd_lo_r - 1'b1);

  logic          ovl_r, mat_r, nbf_r;
  logic [IW-1:0] m_idx_r;
  logic [PW-1:0] m_hi_r;
  logic [7:0]    m_prot_r;
  logic [1:0]    m_kind_r;
  logic [TABLE_SLOTS-1:0] kill_r;
  logic [CW-1:0] kcnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.scan_clr) begin
      ovl_r <= 1'b0; mat_r <= 1'b0; nbf_r <= 1'b0; kill_r <= '0; kcnt_r <= '0;
    end else if (ev_v_r) begin
      if (hit_rng) begin
        ovl_r <= 1'b1;
        kill_r[ev_idx_r] <= 1'b1;
        kcnt_r <= kcnt_r + 1'b1;
      end
      if (hit_in && !mat_r) begin
        mat_r <= 1'b1; m_idx_r <= ev_idx_r; m_prot_r <= rd_prot_r;
        m_kind_r <= rd_kind_r; m_hi_r <= rd_hi_r;
      end else if (nb && !mat_r && !nbf_r && !hit_in) begin
        nbf_r <= 1'b1; m_idx_r <= ev_idx_r; m_prot_r <= rd_prot_r;
        m_kind_r <= rd_kind_r; m_hi_r <= rd_hi_r;
      end
    end
  end

  // lowest free slot
  logic          free_any;
  logic [IW-1:0] free_idx;
  always_comb begin
    free_any = 1'b0; free_idx = '0;
    for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin free_any = 1'b1; free_idx = IW'(i); end
    end
  end

  logic [ADDR_BITS-1:0] grow_sz;
  logic                 over_lim;
  assign grow_sz  = {m_hi_r, {PAGE_SHIFT{1'b0}}} - page;
  assign over_lim = ({{(64-ADDR_BITS){1'b0}}, grow_sz} > {16'd0, stack_limit_r});

  logic [3:0]           st;
  logic [IW-1:0]        idx;
  logic [IW-1:0]        tgt_idx;
  logic                 show_m, tgt_ok;
  logic [TABLE_SLOTS-1:0] valid_nxt;
  logic [CW-1:0]        count_nxt;

  assign tgt_idx = IW'(tgt_r);

  always_comb begin
    st = ST_DONE; idx = '0; show_m = 1'b0;
    we = 1'b0; wa = '0; wlo = '0; whi = '0; wfull = 1'b0;
    valid_nxt = valid_r; count_nxt = count_r;
    tgt_ok = ({26'd0, tgt_r} < TABLE_SLOTS) && valid_r[tgt_idx];
    case (op_r)
      OP_ADD: begin
        if (misal) st = ST_MISALIGNED;
        else if (empty) st = ST_EMPTY;
        else if (ovl_r) st = ST_OVERLAP;
        else if (!free_any) st = ST_FULL;
        else begin
          idx = free_idx; we = 1'b1; wa = free_idx; wfull = 1'b1;
          wlo = s_r[ADDR_BITS-1:PAGE_SHIFT]; whi = e_r[ADDR_BITS-1:PAGE_SHIFT];
          valid_nxt[free_idx] = 1'b1; count_nxt = count_r + 1'b1;
        end
      end
      OP_FAULT: begin
        if (mat_r) begin
          show_m = 1'b1; idx = m_idx_r;
          if (m_kind_r == KIND_GUARD) st = ST_GUARD;
          else if (wr_r && ((m_prot_r & wmask_r) == 8'd0)) st = ST_WDENIED;
          else st = ST_MAP;
        end else if (nbf_r) begin
          show_m = 1'b1; idx = m_idx_r;
          if (over_lim) st = ST_STACKLIM;
          else begin
            st = ST_GROWN; we = 1'b1; wa = m_idx_r;
            wlo = s_r[ADDR_BITS-1:PAGE_SHIFT];
          end
        end else st = ST_NOREGION;
      end
      OP_REMOVE: begin
        if (tgt_ok) begin
          valid_nxt[tgt_idx] = 1'b0; count_nxt = count_r - 1'b1;
        end else st = ST_NOTFOUND;
      end
      OP_RANGE: begin
        valid_nxt = valid_r & ~kill_r; count_nxt = count_r - kcnt_r;
      end
      OP_CLEAR: begin
        valid_nxt = '0; count_nxt = '0;
      end
      default: st = ST_DONE;
    endcase
    if (!cmd.commit) we = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0; count_r <= '0; out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.commit;
      if (cmd.commit) begin
        valid_r <= valid_nxt; count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status       <= st;
      out_entry_index  <= 6'(idx);
      out_fault_page   <= (op_r == OP_FAULT) ? 48'(page) : 48'd0;
      out_region_prot  <= show_m ? m_prot_r : 8'd0;
      out_region_kind  <= show_m ? m_kind_r : 2'd0;
      out_region_count <= 7'(count_nxt);
    end
  end

  `MRT_ASSERT(a_count_range, clk, rst_n, (count_r <= CW'(TABLE_SLOTS)), "count overflow")
  `MRT_ASSERT_NEXT(a_out_after_commit, clk, rst_n, cmd.commit, out_valid, "missing result")
  `MRT_ASSERT(a_count_match, clk, rst_n, (count_r == CW'($countones(valid_r))), "count drift")
endmodule

[rtl/core/memory_region_table.sv]
// ----------------------------------------------------------------------------
// memory_region_table
// Table of non-overlapping page-aligned address regions with fault check.
// ----------------------------------------------------------------------------
// Usage: drive the item on in_* and raise start while busy is low; the item
// is taken at that edge. Every item gives one result on out_* marked by
// out_valid for a single cycle; the receiver cannot hold it off.
// Sequence: clear, remove entry and rejected adds (misaligned or empty) pass
// through latch, scan index clear and commit, then the registered result strobe.
// Add, fault check and remove range also walk every slot through the slot
// memory, one read a cycle, before the commit; that scan sets the rate.
// busy drops in the cycle the result is shown, so the next item can be taken
// there; a new item is not taken before the result of the last one is shown.
// Configuration: write cfg_index/cfg_data with cfg_valid; cfg_ready is
// always high. Write only while busy is low.
// Reset clears all slots (valid bits), the count, and loads the register
// defaults: stack limit 8 MiB, write permit mask 2. No clearing pass.
// ----------------------------------------------------------------------------
module memory_region_table
  import mrt_pkg::*;
#(
  parameter int TABLE_SLOTS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           in_op,
  input  logic [ADDR_BITS-1:0] in_start_addr,
  input  logic [ADDR_BITS-1:0] in_end_addr,
  input  logic [7:0]           in_prot_bits,
  input  logic [1:0]           in_kind_code,
  input  logic                 in_is_write,
  input  logic [5:0]           in_target_entry,
  output logic                 out_valid,
  output logic [3:0]           out_status,
  output logic [5:0]           out_entry_index,
  output logic [47:0]          out_fault_page,
  output logic [7:0]           out_region_prot,
  output logic [1:0]           out_region_kind,
  output logic [6:0]           out_region_count,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [47:0]          cfg_data
);
  mrt_cmd_t  cmd;
  mrt_stat_t stat;

  assign cfg_ready = 1'b1;

  mrt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .stat(stat), .cmd(cmd)
  );

  mrt_datapath #(.TABLE_SLOTS(TABLE_SLOTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_op(in_op), .in_start_addr(in_start_addr), .in_end_addr(in_end_addr),
    .in_prot_bits(in_prot_bits), .in_kind_code(in_kind_code),
    .in_is_write(in_is_write), .in_target_entry(in_target_entry),
    .out_valid(out_valid), .out_status(out_status),
    .out_entry_index(out_entry_index), .out_fault_page(out_fault_page),
    .out_region_prot(out_region_prot), .out_region_kind(out_region_kind),
    .out_region_count(out_region_count)
  );
endmodule
